/* src/ptt_pkg.sv */
package ptt_pkg;

   localparam int TimeW     = 48;
   localparam int PeriodW   = 31;
   localparam int SlotInW   = 8;
   localparam int SlotOutW  = 6;
   localparam int OpW       = 2;
   localparam int KindW     = 2;
   localparam int StatusW   = 2;
   localparam int ReqDataW  = 88;
   localparam int RspDataW  = 56;

   localparam int DefaultSlots = 8;

   localparam logic [TimeW-1:0] IdleWait = TimeW'(200);
   localparam logic [PeriodW-1:0] MinPeriod = PeriodW'(1);

   typedef enum logic [OpW-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [KindW-1:0] {
      KIND_SET      = 2'd0,
      KIND_CLEAR    = 2'd1,
      KIND_FIRED    = 2'd2,
      KIND_DEADLINE = 2'd3
   } kind_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SET_SCAN,
      S_SET_ADD,
      S_SET_WR,
      S_SET_FULL,
      S_CLR,
      S_TK_RD,
      S_TK_CHK,
      S_TK_FIRE,
      S_TK_REC,
      S_TK_RESET,
      S_TK_WB,
      S_TK_MIN,
      S_TK_ADV,
      S_TK_END,
      S_TK_DL
   } state_type;

   // one result on its way to the output register
   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      status_type            status;
      logic [SlotOutW-1:0]   slot;
      logic [TimeW-1:0]      deadline;
      logic                  last;
   } emit_type;

   typedef struct packed {
      logic due_we;
      logic per_we;
   } mem_wr_type;

endpackage

/* src/ptt_ram.sv */
module ptt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/ptt_alu.sv */
module ptt_alu (
   input  logic [ptt_pkg::TimeW-1:0] a,
   input  logic [ptt_pkg::TimeW-1:0] b,
   output logic [ptt_pkg::TimeW-1:0] sum,
   output logic                      a_le_b
);

   logic [ptt_pkg::TimeW:0] raw;

   always_comb begin
      raw    = {1'b0, a} + {1'b0, b};
      // saturate at the top of the time range
      sum    = raw[ptt_pkg::TimeW] ? {ptt_pkg::TimeW{1'b1}} : raw[ptt_pkg::TimeW-1:0];
      a_le_b = (a <= b);
   end

endmodule

/* src/ptt_seq.sv */
module ptt_seq #(
   parameter int SLOTS = ptt_pkg::DefaultSlots,
   parameter int AW    = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ptt_pkg::OpW-1:0]       req_op,
   input  logic [ptt_pkg::SlotInW-1:0]   req_slot,
   input  logic [ptt_pkg::PeriodW-1:0]   req_period,
   input  logic [ptt_pkg::TimeW-1:0]     req_now,
   output logic                          req_ready,
   input  logic                          out_free,
   output ptt_pkg::emit_type             emit,
   output logic [ptt_pkg::TimeW-1:0]     alu_a,
   output logic [ptt_pkg::TimeW-1:0]     alu_b,
   input  logic [ptt_pkg::TimeW-1:0]     alu_sum,
   input  logic                          alu_le,
   output logic [AW-1:0]                 mem_addr,
   output ptt_pkg::mem_wr_type           mem_wr,
   output logic [ptt_pkg::TimeW-1:0]     due_wdata,
   output logic [ptt_pkg::PeriodW-1:0]   per_wdata,
   input  logic [ptt_pkg::TimeW-1:0]     due_rdata,
   input  logic [ptt_pkg::PeriodW-1:0]   per_rdata
);

   localparam logic [AW-1:0] LastIdx = AW'(SLOTS - 1);

   ptt_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                 cur_ff, cur_in;
   logic [SLOTS-1:0]              in_use_ff, in_use_in;
   logic [ptt_pkg::SlotInW-1:0]   slot_ff, slot_in;
   logic [ptt_pkg::PeriodW-1:0]   period_ff, period_in;
   logic [ptt_pkg::TimeW-1:0]     now_ff, now_in;
   logic [ptt_pkg::TimeW-1:0]     due_ff, due_in;
   logic [ptt_pkg::PeriodW-1:0]   per_ff, per_in;
   logic [ptt_pkg::TimeW-1:0]     best_ff, best_in;
   logic                          found_ff, found_in;
   logic                          clr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ptt_pkg::S_IDLE;
         in_use_ff <= '0;
         cur_ff    <= '0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_use_ff <= in_use_in;
         cur_ff    <= cur_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      period_ff <= period_in;
      now_ff    <= now_in;
      due_ff    <= due_in;
      per_ff    <= per_in;
      best_ff   <= best_in;
   end

   // clear hits only an in-range slot that is in use
   always_comb begin
      if (slot_ff < ptt_pkg::SlotInW'(SLOTS)) begin
         clr_hit = in_use_ff[slot_ff[AW-1:0]];
      end else begin
         clr_hit = 1'b0;
      end
   end

   assign mem_addr  = cur_ff;
   assign due_wdata = due_ff;
   assign per_wdata = period_ff;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      in_use_in = in_use_ff;
      slot_in   = slot_ff;
      period_in = period_ff;
      now_in    = now_ff;
      due_in    = due_ff;
      per_in    = per_ff;
      best_in   = best_ff;
      found_in  = found_ff;
      req_ready = 1'b0;
      alu_a     = now_ff;
      alu_b     = due_ff;
      mem_wr    = '0;
      emit          = '0;
      emit.kind     = ptt_pkg::KIND_SET;
      emit.status   = ptt_pkg::ST_OK;

      unique case (state_ff)
         ptt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               slot_in   = req_slot;
               period_in = (req_period == '0) ? ptt_pkg::MinPeriod : req_period;
               now_in    = req_now;
               cur_in    = '0;
               found_in  = 1'b0;
               unique case (ptt_pkg::op_type'(req_op))
                  ptt_pkg::OP_SET:   state_in = ptt_pkg::S_SET_SCAN;
                  ptt_pkg::OP_CLEAR: state_in = ptt_pkg::S_CLR;
                  ptt_pkg::OP_TICK:  state_in = ptt_pkg::S_TK_RD;
                  default:           state_in = ptt_pkg::S_IDLE;
               endcase
            end
         end

         ptt_pkg::S_SET_SCAN: begin
            if (!in_use_ff[cur_ff]) begin
               state_in = ptt_pkg::S_SET_ADD;
            end else if (cur_ff == LastIdx) begin
               state_in = ptt_pkg::S_SET_FULL;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         ptt_pkg::S_SET_ADD: begin
            alu_a    = now_ff;
            alu_b    = ptt_pkg::TimeW'(period_ff);
            due_in   = alu_sum;
            state_in = ptt_pkg::S_SET_WR;
         end

         ptt_pkg::S_SET_WR: begin
            emit.valid = 1'b1;
            emit.kind  = ptt_pkg::KIND_SET;
            emit.slot  = ptt_pkg::SlotOutW'(cur_ff);
            emit.last  = 1'b1;
            if (out_free) begin
               mem_wr.due_we     = 1'b1;
               mem_wr.per_we     = 1'b1;
               in_use_in[cur_ff] = 1'b1;
               state_in          = ptt_pkg::S_IDLE;
            end
         end

         ptt_pkg::S_SET_FULL: begin
            emit.valid  = 1'b1;
            emit.kind   = ptt_pkg::KIND_SET;
            emit.status = ptt_pkg::ST_FULL;
            emit.last   = 1'b1;
            if (out_free) begin
               state_in = ptt_pkg::S_IDLE;
            end
         end

         ptt_pkg::S_CLR: begin
            emit.valid  = 1'b1;
            emit.kind   = ptt_pkg::KIND_CLEAR;
            emit.status = clr_hit ? ptt_pkg::ST_OK : ptt_pkg::ST_IGNORED;
            emit.slot   = slot_ff[ptt_pkg::SlotOutW-1:0];
            emit.last   = 1'b1;
            if (out_free) begin
               if (clr_hit) begin
                  in_use_in[slot_ff[AW-1:0]] = 1'b0;
               end
               state_in = ptt_pkg::S_IDLE;
            end
         end

         // store read address settles here, data comes back next cycle
         ptt_pkg::S_TK_RD: begin
            state_in = ptt_pkg::S_TK_CHK;
         end

         ptt_pkg::S_TK_CHK: begin
            alu_a  = due_rdata;
            alu_b  = now_ff;
            due_in = due_rdata;
            per_in = per_rdata;
            if (!in_use_ff[cur_ff]) begin
               state_in = ptt_pkg::S_TK_ADV;
            end else if (alu_le) begin
               state_in = ptt_pkg::S_TK_FIRE;
            end else begin
               state_in = ptt_pkg::S_TK_MIN;
            end
         end

         ptt_pkg::S_TK_FIRE: begin
            emit.valid = 1'b1;
            emit.kind  = ptt_pkg::KIND_FIRED;
            emit.slot  = ptt_pkg::SlotOutW'(cur_ff);
            alu_a      = due_ff;
            alu_b      = ptt_pkg::TimeW'(per_ff);
            if (out_free) begin
               due_in   = alu_sum;
               state_in = ptt_pkg::S_TK_REC;
            end
         end

         ptt_pkg::S_TK_REC: begin
            alu_a = due_ff;
            alu_b = now_ff;
            // still not ahead of now: restart from now
            state_in = alu_le ? ptt_pkg::S_TK_RESET : ptt_pkg::S_TK_WB;
         end

         ptt_pkg::S_TK_RESET: begin
            alu_a    = now_ff;
            alu_b    = ptt_pkg::TimeW'(per_ff);
            due_in   = alu_sum;
            state_in = ptt_pkg::S_TK_WB;
         end

         ptt_pkg::S_TK_WB: begin
            mem_wr.due_we = 1'b1;
            state_in      = ptt_pkg::S_TK_MIN;
         end

         ptt_pkg::S_TK_MIN: begin
            alu_a = best_ff;
            alu_b = due_ff;
            if (!found_ff || !alu_le) begin
               best_in  = due_ff;
               found_in = 1'b1;
            end
            state_in = ptt_pkg::S_TK_ADV;
         end

         ptt_pkg::S_TK_ADV: begin
            if (cur_ff == LastIdx) begin
               state_in = ptt_pkg::S_TK_END;
            end else begin
               cur_in   = cur_ff + 1'b1;
               state_in = ptt_pkg::S_TK_RD;
            end
         end

         ptt_pkg::S_TK_END: begin
            alu_a = now_ff;
            alu_b = ptt_pkg::IdleWait;
            if (!found_ff) begin
               best_in = alu_sum;
            end
            state_in = ptt_pkg::S_TK_DL;
         end

         ptt_pkg::S_TK_DL: begin
            emit.valid    = 1'b1;
            emit.kind     = ptt_pkg::KIND_DEADLINE;
            emit.deadline = best_ff;
            emit.last     = 1'b1;
            if (out_free) begin
               state_in = ptt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ptt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* src/periodic_timer_table_core.sv */
// set scans for a free slot, one slot a cycle, then adds the period and writes it; clear frees a used slot
// tick reads each slot, fires and re-arms the due ones and tracks the soonest deadline,
// as one saturating adder/comparator and single-port period and due stores serve every step
// throughput: one request at a time; the next is taken once the sequencer returns to idle,
// results drain through a one-deep output register
// reset clears the in-use flags and sequencer; period and due stores are left as they are
module periodic_timer_table_core #(
   parameter int SLOTS = ptt_pkg::DefaultSlots
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // slot [7:0], period [38:8], now [86:39], zero [87]
   input  logic [ptt_pkg::ReqDataW-1:0]   req_tdata,
   // op [1:0]
   input  logic [ptt_pkg::OpW-1:0]        req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status [1:0], slot_out [7:2], deadline [55:8]
   output logic [ptt_pkg::RspDataW-1:0]   rsp_tdata,
   // kind [1:0]
   output logic [ptt_pkg::KindW-1:0]      rsp_tuser,
   output logic                           rsp_tlast
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   ptt_pkg::emit_type           emit;
   ptt_pkg::mem_wr_type         mem_wr;
   logic                        out_free;
   logic [ptt_pkg::TimeW-1:0]   alu_a, alu_b, alu_sum;
   logic                        alu_le;
   logic [AW-1:0]               mem_addr;
   logic [ptt_pkg::TimeW-1:0]   due_wdata, due_rdata;
   logic [ptt_pkg::PeriodW-1:0] per_wdata, per_rdata;

   logic                        rsp_valid_ff, rsp_valid_in;
   ptt_pkg::emit_type           rsp_ff, rsp_in;

   ptt_seq #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_op     (req_tuser),
      .req_slot   (req_tdata[7:0]),
      .req_period (req_tdata[38:8]),
      .req_now    (req_tdata[86:39]),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .emit       (emit),
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .alu_sum    (alu_sum),
      .alu_le     (alu_le),
      .mem_addr   (mem_addr),
      .mem_wr     (mem_wr),
      .due_wdata  (due_wdata),
      .per_wdata  (per_wdata),
      .due_rdata  (due_rdata),
      .per_rdata  (per_rdata)
   );

   ptt_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sum    (alu_sum),
      .a_le_b (alu_le)
   );

   ptt_ram #(
      .WIDTH (ptt_pkg::TimeW),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_due_ram (
      .clock (clock),
      .we    (mem_wr.due_we),
      .waddr (mem_addr),
      .wdata (due_wdata),
      .raddr (mem_addr),
      .rdata (due_rdata)
   );

   ptt_ram #(
      .WIDTH (ptt_pkg::PeriodW),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_per_ram (
      .clock (clock),
      .we    (mem_wr.per_we),
      .waddr (mem_addr),
      .wdata (per_wdata),
      .raddr (mem_addr),
      .rdata (per_rdata)
   );

   // output register: loads when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = emit.valid;
         if (emit.valid) begin
            rsp_in = emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.deadline, rsp_ff.slot, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import ptt_pkg::*;

   localparam int Slots = DefaultSlots;
   localparam int StallLimit = 4000;
   localparam logic [OpW-1:0] OpUnused = 2'd3;
   localparam logic [TimeW-1:0] TimeMax = '1;
   localparam logic [PeriodW-1:0] PeriodMax = '1;

   typedef struct packed {
      kind_type              kind;
      status_type            status;
      logic [SlotOutW-1:0]   slot;
      logic [TimeW-1:0]      deadline;
      logic                  last;
   } rsp_item;

   typedef struct {
      logic [OpW-1:0]      op;
      logic [SlotInW-1:0]  slot;
      logic [PeriodW-1:0]  period;
      logic [TimeW-1:0]    now;
      logic                typed;
      rsp_item             want;
   } script_row;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // slot [7:0], period [38:8], now [86:39], zero [87]
   logic [ReqDataW-1:0]   req_tdata;
   // op [1:0]
   logic [OpW-1:0]        req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // status [1:0], slot_out [7:2], deadline [55:8]
   logic [RspDataW-1:0]   rsp_tdata;
   // kind [1:0]
   logic [KindW-1:0]      rsp_tuser;
   logic                  rsp_tlast;

   // timer table mirror
   logic                  busy [Slots];
   logic [PeriodW-1:0]    per_tab [Slots];
   logic [TimeW-1:0]      due_tab [Slots];

   rsp_item   pending_rsp [$];
   rsp_item   fresh_rsp [$];
   script_row script [$];
   int        error_count = 0;
   int        idle_pct = 0;
   int        stall_pct = 0;
   int        quiet_cycles = 0;

   periodic_timer_table_core #(
      .SLOTS(Slots)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_item make_rsp(kind_type kind, status_type status,
         logic [SlotOutW-1:0] slot, logic [TimeW-1:0] deadline, logic last);
      rsp_item r;
      r.kind     = kind;
      r.status   = status;
      r.slot     = slot;
      r.deadline = deadline;
      r.last     = last;
      return r;
   endfunction

   function automatic script_row make_row(logic [OpW-1:0] op, logic [SlotInW-1:0] slot,
         logic [PeriodW-1:0] period, logic [TimeW-1:0] now, logic typed, rsp_item want);
      script_row r;
      r.op     = op;
      r.slot   = slot;
      r.period = period;
      r.now    = now;
      r.typed  = typed;
      r.want   = want;
      return r;
   endfunction

   function automatic logic [TimeW-1:0] sat_sum(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeW] ? TimeMax : s[TimeW-1:0];
   endfunction

   // applies one request to the mirror and lists the results it causes
   function automatic void timer_table_step(logic [OpW-1:0] op, logic [SlotInW-1:0] slot,
         logic [PeriodW-1:0] period, logic [TimeW-1:0] now);
      logic [PeriodW-1:0] per;
      logic [TimeW-1:0]   nx;
      logic [TimeW-1:0]   soonest;
      logic               found;
      logic               placed;
      fresh_rsp.delete();
      case (op)
         OP_SET: begin
            per = (period == '0) ? MinPeriod : period;
            placed = 1'b0;
            for (int i = 0; i < Slots; i++) begin
               if (!placed && !busy[i]) begin
                  busy[i] = 1'b1;
                  per_tab[i] = per;
                  due_tab[i] = sat_sum(now, TimeW'(per));
                  placed = 1'b1;
                  fresh_rsp.push_back(make_rsp(KIND_SET, ST_OK, SlotOutW'(i), '0, 1'b1));
               end
            end
            if (!placed)
               fresh_rsp.push_back(make_rsp(KIND_SET, ST_FULL, '0, '0, 1'b1));
         end
         OP_CLEAR: begin
            if (slot < Slots && busy[slot]) begin
               busy[slot] = 1'b0;
               fresh_rsp.push_back(make_rsp(KIND_CLEAR, ST_OK, slot[SlotOutW-1:0], '0, 1'b1));
            end else begin
               fresh_rsp.push_back(make_rsp(KIND_CLEAR, ST_IGNORED, slot[SlotOutW-1:0],
                                            '0, 1'b1));
            end
         end
         OP_TICK: begin
            for (int i = 0; i < Slots; i++) begin
               if (busy[i] && due_tab[i] <= now) begin
                  fresh_rsp.push_back(make_rsp(KIND_FIRED, ST_OK, SlotOutW'(i), '0, 1'b0));
                  nx = sat_sum(due_tab[i], TimeW'(per_tab[i]));
                  // a slot that fell behind restarts from now
                  if (nx <= now) nx = sat_sum(now, TimeW'(per_tab[i]));
                  due_tab[i] = nx;
               end
            end
            found = 1'b0;
            soonest = '0;
            for (int i = 0; i < Slots; i++) begin
               if (busy[i] && (!found || due_tab[i] < soonest)) begin
                  soonest = due_tab[i];
                  found = 1'b1;
               end
            end
            if (!found) soonest = sat_sum(now, IdleWait);
            fresh_rsp.push_back(make_rsp(KIND_DEADLINE, ST_OK, '0, soonest, 1'b1));
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(logic [OpW-1:0] op, logic [SlotInW-1:0] slot,
         logic [PeriodW-1:0] period, logic [TimeW-1:0] now, logic typed, rsp_item want);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, now, period, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      timer_table_step(op, slot, period, now);
      if (typed) begin
         pending_rsp.push_back(want);
      end else begin
         foreach (fresh_rsp[k]) pending_rsp.push_back(fresh_rsp[k]);
      end
   endtask

   task automatic report_field(string field, logic [TimeW-1:0] want_v, logic [TimeW-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
         error_count++;
      end
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_item want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none got kind %0d slot %0d",
                     $time, rsp_tuser, rsp_tdata[7:2]);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            report_field("kind", TimeW'(want.kind), TimeW'(rsp_tuser));
            report_field("status", TimeW'(want.status), TimeW'(rsp_tdata[1:0]));
            report_field("slot_out", TimeW'(want.slot), TimeW'(rsp_tdata[7:2]));
            report_field("deadline", want.deadline, rsp_tdata[55:8]);
            report_field("last", TimeW'(want.last), TimeW'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                  sender_idle [4] = '{0, 54, 0, 6};
      int                  rcv_stall [4]   = '{0, 0, 54, 6};
      logic [OpW-1:0]      op;
      logic [SlotInW-1:0]  slot;
      logic [PeriodW-1:0]  period;
      logic [TimeW-1:0]    now;
      logic [TimeW-1:0]    cur_time;
      int                  pick;

      foreach (busy[i]) busy[i] = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_SET;

      // empty table, then fill it, overflow it and fire everything at the time limit
      script.push_back(make_row(OP_TICK, 0, 0, 0, 1'b1,
                                make_rsp(KIND_DEADLINE, ST_OK, 0, 200, 1'b1)));
      script.push_back(make_row(OP_TICK, 0, 0, TimeMax, 1'b1,
                                make_rsp(KIND_DEADLINE, ST_OK, 0, TimeMax, 1'b1)));
      script.push_back(make_row(OP_CLEAR, 0, 0, 0, 1'b1,
                                make_rsp(KIND_CLEAR, ST_IGNORED, 0, 0, 1'b1)));
      script.push_back(make_row(OP_CLEAR, 255, 0, 0, 1'b1,
                                make_rsp(KIND_CLEAR, ST_IGNORED, 63, 0, 1'b1)));
      script.push_back(make_row(OP_CLEAR, 8, 0, 0, 1'b1,
                                make_rsp(KIND_CLEAR, ST_IGNORED, 8, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 0, 0, 0, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 0, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 255, PeriodMax, TimeMax, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 1, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 0, 5, 100, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 2, 0, 1'b1)));
      script.push_back(make_row(OP_TICK, 0, 0, 1, 1'b0, '0));
      script.push_back(make_row(OP_TICK, 0, 0, 50, 1'b0, '0));
      script.push_back(make_row(OpUnused, 5, 7, 9, 1'b0, '0));
      script.push_back(make_row(OP_SET, 0, 3, 60, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 3, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 0, 1000, 60, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 4, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 8'h55, 31'h5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 5, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 8'hAA, 31'h2AAA_AAAA, 48'h5555_5555_5555, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 6, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 0, 7, 61, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 7, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 0, 1, 0, 1'b1,
                                make_rsp(KIND_SET, ST_FULL, 0, 0, 1'b1)));
      script.push_back(make_row(OP_TICK, 0, 0, TimeMax - 1, 1'b0, '0));
      script.push_back(make_row(OP_TICK, 0, 0, TimeMax, 1'b0, '0));
      script.push_back(make_row(OP_CLEAR, 3, 0, 0, 1'b1,
                                make_rsp(KIND_CLEAR, ST_OK, 3, 0, 1'b1)));
      script.push_back(make_row(OP_CLEAR, 3, 0, 0, 1'b1,
                                make_rsp(KIND_CLEAR, ST_IGNORED, 3, 0, 1'b1)));
      script.push_back(make_row(OP_SET, 0, 9, 0, 1'b1,
                                make_rsp(KIND_SET, ST_OK, 3, 0, 1'b1)));
      script.push_back(make_row(OP_TICK, 0, 0, 10, 1'b0, '0));
      script.push_back(make_row(OP_CLEAR, 7, 0, 0, 1'b1,
                                make_rsp(KIND_CLEAR, ST_OK, 7, 0, 1'b1)));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k])
         send_request(script[k].op, script[k].slot, script[k].period, script[k].now,
                      script[k].typed, script[k].want);

      cur_time = TimeW'($urandom_range(0, 100000));
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = sender_idle[phase];
         stall_pct = rcv_stall[phase];
         for (int n = 0; n < 39; n++) begin
            pick = $urandom_range(99);
            if (pick < 30) op = OP_SET;
            else if (pick < 52) op = OP_CLEAR;
            else if (pick < 96) op = OP_TICK;
            else op = OpUnused;

            pick = $urandom_range(99);
            if (pick < 75) slot = SlotInW'($urandom_range(0, 7));
            else if (pick < 85) slot = SlotInW'($urandom_range(8, 63));
            else slot = SlotInW'($urandom_range(0, 255));

            pick = $urandom_range(99);
            if (pick < 80) period = PeriodW'($urandom_range(1, 40));
            else if (pick < 90) period = '0;
            else period = PeriodW'($urandom);

            // mostly a steadily advancing clock, sometimes wild times or times near the top
            if (op == OP_TICK) cur_time = cur_time + TimeW'($urandom_range(0, 30));
            pick = $urandom_range(99);
            if (pick < 85) now = cur_time;
            else if (pick < 95) now = TimeW'({$urandom, $urandom});
            else now = TimeMax - TimeW'($urandom_range(0, 3));

            send_request(op, slot, period, now, 1'b0, '0);
         end
         // hold off until the block has drained every request
         req_tvalid <= 1'b0;
         while (pending_rsp.size() != 0) @(posedge clock);
      end

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
